[rtl/core/cfm_pkg.sv]
package cfm_pkg;

   localparam int TICK_HZ_DEFAULT = 100000;
   localparam int STAMP_BITS_DEFAULT = 16;
   localparam int CENTI_SCALE = 100;
   localparam int PPM_MAX = 255;

   localparam logic [7:0] PPM_RESET = 8'd4;
   localparam logic [15:0] FREQ_MAX = 16'hFFFF;
   localparam logic [15:0] WRAP_MAX = 16'hFFFF;

   localparam logic MODE_CAPTURE = 1'b0;
   localparam logic MODE_WRAP = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [15:0] capture_stamp;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] freq_centi_hz;
      logic [31:0] elapsed_ticks;
      logic        saturated;
   } rsp_payload_type;

endpackage

[rtl/core/capture_frequency_meter_core.sv]
// Frequency meter fed by timer events.
// req channel: one item per timer event, either a capture edge with its timer
// stamp or a timer wrap. csr channel: one write sets pulses_per_measure; it is
// always ready and takes effect for the next event.
// An event that does not close a measurement is absorbed without leaving
// idle and gives no result. A capture that closes a measurement yields one
// rsp item: the multiplier step forms the numerator, then a shift and
// subtract unit runs one quotient bit a cycle over the numerator width
// (32 bits at the default tick rate), then the final step loads the output
// register and raises rsp_valid; req_ready is low meanwhile.
// The output register holds the result until the receiver takes it. While it
// waits, events that do not close a measurement are still accepted; a closing
// one runs its division and then waits in the final step for the register.
// Reset clears the measurement state, empties the output register and sets
// pulses_per_measure to 4.
module capture_frequency_meter_core
   import cfm_pkg::*;
#(
   parameter int TICK_HZ = TICK_HZ_DEFAULT,
   parameter int STAMP_BITS = STAMP_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [7:0]      csr_data
);

   localparam longint CENTI_TICKS = longint'(TICK_HZ) * longint'(CENTI_SCALE);
   localparam int NUM_BITS = $clog2(longint'(PPM_MAX) * CENTI_TICKS + 64'd1);
   localparam int CNT_BITS = $clog2(NUM_BITS);
   localparam logic [63:0] STAMP_MASK = (64'd1 << STAMP_BITS) - 64'd1;
   localparam logic [NUM_BITS-1:0] CENTI_TICKS_W = CENTI_TICKS[NUM_BITS-1:0];
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(NUM_BITS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type             state_ff, state_in;
   logic [7:0]            ppm_ff, ppm_in;
   logic [7:0]            edge_count_ff, edge_count_in;
   logic [15:0]           start_stamp_ff, start_stamp_in;
   logic [15:0]           wrap_count_ff, wrap_count_in;
   logic [31:0]           span_ff, span_in;
   logic [31:0]           rem_ff, rem_in;
   logic [NUM_BITS-1:0]   quo_ff, quo_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                  req_fire;
   logic                  closing;
   logic [15:0]           stamp_masked;
   logic [15:0]           eff_start;
   logic [15:0]           eff_wrap;
   logic [63:0]           wrap_term;
   logic [32:0]           rem_shift;
   logic [32:0]           rem_diff;
   logic                  qbit;
   logic                  freq_over;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assign req_fire = req_valid && req_ready;
   assign stamp_masked = req_data.capture_stamp & STAMP_MASK[15:0];
   assign eff_start = (edge_count_ff == 8'd0) ? stamp_masked : start_stamp_ff;
   assign eff_wrap = (edge_count_ff == 8'd0) ? 16'd0 : wrap_count_ff;
   assign wrap_term = {48'd0, eff_wrap} << STAMP_BITS;
   assign closing = (req_data.mode == MODE_CAPTURE) && (edge_count_ff >= ppm_ff);

   assign rem_shift = {rem_ff, quo_ff[NUM_BITS-1]};
   assign rem_diff = rem_shift - {1'b0, span_ff};
   assign qbit = !rem_diff[32];
   assign freq_over = (quo_ff[NUM_BITS-1:16] != '0);

   always_comb begin
      state_in = state_ff;
      ppm_in = ppm_ff;
      edge_count_in = edge_count_ff;
      start_stamp_in = start_stamp_ff;
      wrap_count_in = wrap_count_ff;
      span_in = span_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid && csr_ready) begin
         ppm_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.mode == MODE_WRAP) begin
                  if (edge_count_ff != 8'd0 && wrap_count_ff != WRAP_MAX) begin
                     wrap_count_in = wrap_count_ff + 16'd1;
                  end
               end else if (closing) begin
                  span_in = wrap_term[31:0] + {16'd0, stamp_masked} - {16'd0, eff_start};
                  edge_count_in = 8'd0;
                  wrap_count_in = 16'd0;
                  state_in = ST_MUL;
               end else begin
                  start_stamp_in = eff_start;
                  wrap_count_in = eff_wrap;
                  edge_count_in = edge_count_ff + 8'd1;
               end
            end
         end
         ST_MUL: begin
            quo_in = NUM_BITS'(ppm_ff) * CENTI_TICKS_W;
            rem_in = 32'd0;
            count_in = CNT_LAST;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = qbit ? rem_diff[31:0] : rem_shift[31:0];
            quo_in = {quo_ff[NUM_BITS-2:0], qbit};
            count_in = count_ff - CNT_BITS'(1);
            if (count_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.elapsed_ticks = span_ff;
               if (span_ff == 32'd0 || freq_over) begin
                  rsp_data_in.freq_centi_hz = FREQ_MAX;
                  rsp_data_in.saturated = 1'b1;
               end else begin
                  rsp_data_in.freq_centi_hz = quo_ff[15:0];
                  rsp_data_in.saturated = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      span_ff <= span_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      count_ff <= count_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         ppm_ff <= PPM_RESET;
         edge_count_ff <= 8'd0;
         start_stamp_ff <= 16'd0;
         wrap_count_ff <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ppm_ff <= ppm_in;
         edge_count_ff <= edge_count_in;
         start_stamp_ff <= start_stamp_in;
         wrap_count_ff <= wrap_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && span_ff != 32'd0) |-> (rem_ff < span_ff))
      else $error("division remainder not below divisor");

   a_close_starts_mul: assert property (@(posedge clock) disable iff (reset)
      (req_fire && closing) |=> (state_ff == ST_MUL && edge_count_ff == 8'd0))
      else $error("closing capture did not start the computation");

   a_fin_loads_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && (!rsp_valid_ff || rsp_ready))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not loaded into free output register");

   a_no_wraps_when_closed: assert property (@(posedge clock) disable iff (reset)
      (edge_count_ff == 8'd0) |-> (wrap_count_ff == 16'd0))
      else $error("wraps counted with no measurement open");

endmodule
